// ===== hdl/assert_macros.svh =====
// Assertion macros used by the port checker file.
// Plain concurrent property wrappers on the checker clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m: check failed");
// Same check, also enforced while reset is asserted
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("%m: check failed");
`endif

// ===== hdl/stbm_pkg.sv =====
// Package for the source token boundary marker.
// Types, constants and character classing functions; no dependencies.
package stbm_pkg;

   localparam int MaxNestingDefault = 16;
   localparam int CsrIdxWidth = 2;
   localparam int CsrDataWidth = 8;
   localparam logic [7:0] XorChar = 8'hA4;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_COMMENT  = 2'd0,
      CSR_STRING   = 2'd1,
      CSR_DECIMAL  = 2'd2,
      CSR_EXPONENT = 2'd3
   } csr_idx_type;

   typedef enum logic [3:0] {
      TK_SPACE   = 4'd0,
      TK_TEXT    = 4'd1,
      TK_NUMBER  = 4'd2,
      TK_HEX     = 4'd3,
      TK_OPER    = 4'd4,
      TK_OPEN    = 4'd5,
      TK_CLOSE   = 4'd6,
      TK_STRING  = 4'd7,
      TK_COMMENT = 4'd8,
      TK_EOL     = 4'd9,
      TK_UNREC   = 4'd10
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE     = 3'd0,
      ERR_UNTERM   = 3'd1,
      ERR_MISMATCH = 3'd2,
      ERR_UNCLOSED = 3'd3,
      ERR_OVERFLOW = 3'd4
   } err_type;

   typedef enum logic [1:0] {
      BR_ROUND  = 2'd0,
      BR_SQUARE = 2'd1,
      BR_CURLY  = 2'd2
   } bracket_type;

   typedef struct packed {
      logic [7:0] comment_char;
      logic [7:0] string_char;
      logic [7:0] decimal_char;
      logic [7:0] exponent_char;
   } cfg_type;

   // one byte paired with its lookahead, as queued from front to back
   typedef struct packed {
      logic [7:0] raw;
      logic [7:0] nxt;
      logic       final_b;
   } pair_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic [3:0] token_kind;
      logic       token_start;
      logic [4:0] bracket_depth;
      logic [2:0] error_code;
      logic       last;
   } rsp_type;

   function automatic logic [7:0] as_space(input logic [7:0] c);
      return (c == 8'h09 || c == 8'h0D) ? 8'h20 : c;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_text(input logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_" || c == "@";
   endfunction

   function automatic logic has_mix_set(input logic [7:0] c);
      return c == "." || c == "," || c == ":" || c == "<" || c == ">";
   endfunction

   function automatic logic in_mix_set(input logic [7:0] s, input logic [7:0] c);
      logic r;
      r = 1'b0;
      case (s)
         ".":     r = c == "." || is_digit(c);
         "<":     r = c == "=";
         ">":     r = c == "=" || c == "-";
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic mixes(input logic [7:0] a, input logic [7:0] b);
      logic r;
      if (has_mix_set(a)) begin
         r = in_mix_set(a, b);
      end else if (has_mix_set(b)) begin
         r = in_mix_set(b, a);
      end else begin
         r = 1'b1;
      end
      return r;
   endfunction

   function automatic kind_type kind_of(input logic [7:0] c, input logic [7:0] n,
                                        input cfg_type cfg);
      kind_type k;
      logic op;
      op = ((c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) || c == "^" ||
            c == "|" || c == XorChar) && c != cfg.comment_char && c != cfg.string_char;
      if (is_text(c))                          k = TK_TEXT;
      else if (c == "0" && n == "x")           k = TK_HEX;
      else if (is_digit(c))                    k = TK_NUMBER;
      else if (c == "(" || c == "[" || c == "{") k = TK_OPEN;
      else if (c == ")" || c == "]" || c == "}") k = TK_CLOSE;
      else if (op)                             k = TK_OPER;
      else if (c == cfg.comment_char)          k = TK_COMMENT;
      else if (c == cfg.string_char)           k = TK_STRING;
      else if (c == 8'h0A)                     k = TK_EOL;
      else                                     k = TK_UNREC;
      return k;
   endfunction

   function automatic logic joins(input kind_type rg, input kind_type t,
                                  input logic [7:0] p, input logic [7:0] c,
                                  input logic [7:0] n, input cfg_type cfg);
      logic r;
      r = 1'b0;
      if (!mixes(p, c)) begin
         r = 1'b0;
      end else if (t == rg) begin
         r = 1'b1;
      end else begin
         case (rg)
            TK_TEXT:   r = t == TK_NUMBER;
            TK_HEX:    r = t == TK_NUMBER || (p == "0" && c == "x") ||
                           (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
            TK_NUMBER: r = (c == cfg.decimal_char && is_digit(n)) ||
                           c == cfg.exponent_char ||
                           (p == cfg.exponent_char && (c == "+" || c == "-"));
            default:   r = 1'b0;
         endcase
      end
      return r;
   endfunction

   function automatic bracket_type bracket_code(input logic [7:0] c);
      bracket_type b;
      case (c)
         "[", "]": b = BR_SQUARE;
         "{", "}": b = BR_CURLY;
         default:  b = BR_ROUND;
      endcase
      return b;
   endfunction

endpackage

// ===== hdl/stbm_stream_if.sv =====
// Valid/ready stream interface carrying one payload.
// Depends on nothing; payload type set by parameter.
interface stbm_stream_if #(
   parameter type PayloadType = logic [8:0]
);
   logic       valid;
   logic       ready;
   PayloadType payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/source_token_boundary_marker_unit.sv =====
// Top level of the source token boundary marker.
// Depends on stbm_pkg, stbm_stream_if, stbm_front, stbm_queue, stbm_back.
//
//   channel | dir | payload
//   req     | in  | char_code[7:0], end_of_text
//   rsp     | out | out_char, token_kind, token_start, bracket_depth, error_code, last
//   csr     | in  | csr_we, csr_idx[1:0], csr_wdata[7:0]
//
// One request per cycle while the queue has room; after an end_of_text request
// that follows a held byte, req is not ready until the final pair is pushed. Results
// pass the queue, then the back result register. Reset is synchronous and clears all
// control state. A stalled rsp side fills the two-entry queue, then stalls req.
module source_token_boundary_marker_unit import stbm_pkg::*; #(
   parameter int MaxNesting = MaxNestingDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   stbm_stream_if.sink            req,
   stbm_stream_if.source          rsp,
   input  logic                   csr_we,
   input  logic [CsrIdxWidth-1:0] csr_idx,
   input  logic [CsrDataWidth-1:0] csr_wdata
);
   cfg_type  cfg_ff, cfg_in;
   logic     q_push, q_room, q_valid, q_pop;
   pair_type q_in, q_head;
   logic [8:0] req_bits;
   rsp_type  rsp_bits;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_idx_type'(csr_idx))
            CSR_COMMENT:  cfg_in.comment_char  = csr_wdata;
            CSR_STRING:   cfg_in.string_char   = csr_wdata;
            CSR_DECIMAL:  cfg_in.decimal_char  = csr_wdata;
            CSR_EXPONENT: cfg_in.exponent_char = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{comment_char: 8'd35, string_char: 8'd34,
                     decimal_char: 8'd46, exponent_char: 8'd101};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_bits = req.payload;

   stbm_front u_front (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready),
      .in_char(req_bits[8:1]), .in_end(req_bits[0]),
      .q_push, .q_data(q_in), .q_room
   );

   stbm_queue u_queue (
      .clock, .reset,
      .push(q_push), .push_data(q_in), .room(q_room),
      .head_valid(q_valid), .head_data(q_head), .pop(q_pop)
   );

   stbm_back #(.MaxNesting(MaxNesting)) u_back (
      .clock, .reset, .cfg(cfg_ff),
      .head_valid(q_valid), .head_data(q_head), .pop(q_pop),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp_bits)
   );

   assign rsp.payload = rsp_bits;
endmodule

// ===== hdl/stbm_front.sv =====
// Front stage: holds one byte of lookahead and emits byte/lookahead pairs.
// Depends on stbm_pkg. Up to two pairs per request, fed into the queue.
module stbm_front import stbm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [7:0] in_char,
   input  logic       in_end,
   output logic       q_push,
   output pair_type   q_data,
   input  logic       q_room
);
   logic       held_valid_ff, held_valid_in;
   logic [7:0] held_char_ff, held_char_in;
   logic       second_ff, second_in;   // final pair still owed
   logic [7:0] last_char_ff, last_char_in;

   always_comb begin
      held_valid_in = held_valid_ff;
      held_char_in  = held_char_ff;
      second_in     = second_ff;
      last_char_in  = last_char_ff;
      q_push        = 1'b0;
      q_data        = '0;
      in_ready      = 1'b0;
      if (second_ff) begin
         // emit the final byte with zero lookahead
         q_data = '{raw: last_char_ff, nxt: 8'd0, final_b: 1'b1};
         if (q_room) begin
            q_push    = 1'b1;
            second_in = 1'b0;
         end
      end else begin
         in_ready = q_room;
         if (in_valid && q_room) begin
            if (held_valid_ff) begin
               q_push = 1'b1;
               q_data = '{raw: held_char_ff, nxt: in_char, final_b: 1'b0};
               if (in_end) begin
                  second_in    = 1'b1;
                  last_char_in = in_char;
               end
            end else if (in_end) begin
               q_push = 1'b1;
               q_data = '{raw: in_char, nxt: 8'd0, final_b: 1'b1};
            end
            held_valid_in = !in_end;
            held_char_in  = in_char;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         second_ff     <= 1'b0;
      end else begin
         held_valid_ff <= held_valid_in;
         second_ff     <= second_in;
      end
      held_char_ff <= held_char_in;
      last_char_ff <= last_char_in;
   end
endmodule

// ===== hdl/stbm_queue.sv =====
// Short queue between front and back stages.
// Depends on stbm_pkg. Two entries in registers, pass-through free.
module stbm_queue import stbm_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  pair_type push_data,
   output logic     room,
   output logic     head_valid,
   output pair_type head_data,
   input  logic     pop
);
   pair_type   slot_ff [2];
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic [1:0] cnt_ff, cnt_in;

   assign room       = cnt_ff != 2'd2;
   assign head_valid = cnt_ff != 2'd0;
   assign head_data  = slot_ff[rd_ff];

   always_comb begin
      rd_in  = rd_ff ^ pop;
      wr_in  = wr_ff ^ push;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end
endmodule

// ===== hdl/stbm_back.sv =====
// Back stage: classifies one byte per cycle, unless stalled, into a registered result.
// Depends on stbm_pkg. Keeps token, string, comment and bracket state.
module stbm_back import stbm_pkg::*; #(
   parameter int MaxNesting = MaxNestingDefault
) (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     head_valid,
   input  pair_type head_data,
   output logic     pop,
   output logic     out_valid,
   input  logic     out_ready,
   output rsp_type  out_data
);
   localparam int CntW = $clog2(MaxNesting + 1);
   localparam int IdxW = (MaxNesting > 1) ? $clog2(MaxNesting) : 1;

   kind_type    tok_ff, tok_in;
   logic        str_ff, str_in, cmt_ff, cmt_in;
   logic [7:0]  prior_ff, prior_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   bracket_type stack_ff [MaxNesting];
   logic        push_en;
   logic        valid_ff, valid_in;
   rsp_type     rsp_ff, rsp_in;
   logic [7:0]  c, n;
   kind_type    t, kind;
   logic        start;
   err_type     err;
   bracket_type top;

   assign pop       = head_valid && (!valid_ff || out_ready);
   assign out_valid = valid_ff;
   assign out_data  = rsp_ff;

   always_comb begin
      c     = as_space(head_data.raw);
      n     = head_data.final_b ? 8'd0 : as_space(head_data.nxt);
      t     = kind_of(c, n, cfg);
      top   = (cnt_ff != '0) ? stack_ff[IdxW'(cnt_ff - 1'b1)] : BR_ROUND;
      tok_in = tok_ff;
      str_in = str_ff;
      cmt_in = cmt_ff;
      cnt_in = cnt_ff;
      kind   = TK_SPACE;
      start  = 1'b0;
      err    = ERR_NONE;
      push_en = 1'b0;
      if (cmt_ff) begin
         kind = TK_COMMENT;
         if (c == 8'h0A) cmt_in = 1'b0;
      end else if (str_ff && c == cfg.string_char) begin
         kind   = TK_STRING;
         str_in = 1'b0;
      end else if (str_ff && c != 8'h0A) begin
         kind = TK_STRING;
      end else begin
         if (str_ff) begin
            err    = ERR_UNTERM;
            str_in = 1'b0;
         end
         if (c == 8'h20) begin
            tok_in = TK_SPACE;
         end else if (tok_ff != TK_SPACE && t != TK_OPEN && t != TK_CLOSE &&
                      joins(tok_ff, t, prior_ff, c, n, cfg)) begin
            kind = tok_ff;
         end else begin
            kind   = t;
            start  = 1'b1;
            tok_in = TK_SPACE;
            case (t)
               TK_TEXT, TK_NUMBER, TK_HEX, TK_OPER, TK_UNREC: tok_in = t;
               TK_OPEN: begin
                  if (cnt_ff >= CntW'(MaxNesting)) err = ERR_OVERFLOW;
                  else begin
                     push_en = 1'b1;
                     cnt_in  = cnt_ff + 1'b1;
                  end
               end
               TK_CLOSE: begin
                  if (cnt_ff == '0) err = ERR_MISMATCH;
                  else begin
                     if (top != bracket_code(c)) err = ERR_MISMATCH;
                     cnt_in = cnt_ff - 1'b1;
                  end
               end
               TK_STRING:  str_in = 1'b1;
               TK_COMMENT: cmt_in = 1'b1;
               default: ;
            endcase
         end
      end
      prior_in = c;
      rsp_in.out_char      = head_data.raw;
      rsp_in.token_kind    = kind;
      rsp_in.token_start   = start;
      rsp_in.bracket_depth = 5'(cnt_in);
      rsp_in.error_code    = err;
      rsp_in.last          = head_data.final_b;
      if (head_data.final_b) begin
         if (err == ERR_NONE && str_in) rsp_in.error_code = ERR_UNTERM;
         else if (err == ERR_NONE && cnt_in != '0) rsp_in.error_code = ERR_UNCLOSED;
         tok_in   = TK_SPACE;
         str_in   = 1'b0;
         cmt_in   = 1'b0;
         cnt_in   = '0;
         prior_in = 8'd0;
      end
      valid_in = pop ? 1'b1 : (out_ready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff   <= TK_SPACE;
         str_ff   <= 1'b0;
         cmt_ff   <= 1'b0;
         cnt_ff   <= '0;
         prior_ff <= 8'd0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (pop) begin
            tok_ff   <= tok_in;
            str_ff   <= str_in;
            cmt_ff   <= cmt_in;
            cnt_ff   <= cnt_in;
            prior_ff <= prior_in;
         end
      end
      if (pop) begin
         rsp_ff <= rsp_in;
         if (push_en) stack_ff[IdxW'(cnt_ff)] <= bracket_code(c);
      end
   end
endmodule

// ===== hdl/stbm_checker.sv =====
// Port-level checker for the token boundary marker, bound to the top level.
// Depends on stbm_pkg and assert_macros.svh.
`include "assert_macros.svh"
module stbm_port_checker import stbm_pkg::*; #(
   parameter int MaxNesting = MaxNestingDefault
) (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);
   // nothing comes out in the cycle after reset
   `ASSERT_CLK(a_quiet_after_reset, clock, reset, $past(reset) |-> !rsp_valid)
   // a stalled result holds
   `ASSERT_CLK(a_hold, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_data))
   // space never starts a token
   `ASSERT_CLK(a_space, clock, reset,
      rsp_valid && rsp_data.token_kind == TK_SPACE |-> !rsp_data.token_start)
   // depth never exceeds the nesting limit
   `ASSERT_CLK(a_depth, clock, reset,
      rsp_valid |-> int'(rsp_data.bracket_depth) <= MaxNesting)
endmodule

bind source_token_boundary_marker_unit stbm_port_checker #(.MaxNesting(MaxNesting))
   u_stbm_port_checker (
   .clock(clock), .reset(reset),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.payload)
);

// ===== verif/stbm_checker.sv =====
// Checker for the source token boundary marker: watches the request, result and csr ports,
// predicts every result from its own model of the tokeniser and compares field by field.
// Depends on stbm_pkg for the kind, error and bracket codes and the result layout.
module stbm_checker import stbm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [8:0]  req_payload,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_payload,
   input  logic        csr_we,
   input  logic [1:0]  csr_idx,
   input  logic [7:0]  csr_wdata,
   output int          mismatch_count,
   output int          awaited_count
);

   localparam int StackDepth = MaxNestingDefault;

   // character settings as last written
   logic [7:0] cmt_ch, str_ch, dec_ch, exp_ch;

   // tokeniser state
   logic [7:0]  held_byte, prev_byte;
   logic        held_ok, in_str, in_cmt;
   kind_type    open_kind;
   bracket_type brackets [StackDepth];
   int          depth;

   rsp_type awaited [$];

   function automatic logic [7:0] blank(input logic [7:0] c);
      return (c == 8'h09 || c == 8'h0D) ? " " : c;
   endfunction

   function automatic logic digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   // punctuation with a restricted mixing set; others mix with anything
   function automatic logic restricted(input logic [7:0] c);
      return c == "." || c == "," || c == ":" || c == "<" || c == ">";
   endfunction

   function automatic logic allowed_after(input logic [7:0] s, input logic [7:0] c);
      if (s == ".") return c == "." || digit(c);
      if (s == "<") return c == "=";
      if (s == ">") return c == "=" || c == "-";
      return 1'b0;
   endfunction

   function automatic logic can_mix(input logic [7:0] a, input logic [7:0] b);
      if (restricted(a)) return allowed_after(a, b);
      if (restricted(b)) return allowed_after(b, a);
      return 1'b1;
   endfunction

   function automatic kind_type byte_kind(input logic [7:0] c, input logic [7:0] n);
      logic punct;
      punct = ((c >= 33 && c <= 47) || (c >= 58 && c <= 64) || c == "^" || c == "|" ||
               c == 8'hA4) && c != cmt_ch && c != str_ch;
      if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_" || c == "@")
         return TK_TEXT;
      if (c == "0" && n == "x") return TK_HEX;
      if (digit(c)) return TK_NUMBER;
      if (c == "(" || c == "[" || c == "{") return TK_OPEN;
      if (c == ")" || c == "]" || c == "}") return TK_CLOSE;
      if (punct) return TK_OPER;
      if (c == cmt_ch) return TK_COMMENT;
      if (c == str_ch) return TK_STRING;
      if (c == 8'h0A) return TK_EOL;
      return TK_UNREC;
   endfunction

   function automatic logic continues(input kind_type t, input logic [7:0] p,
                                      input logic [7:0] c, input logic [7:0] n);
      if (!can_mix(p, c)) return 1'b0;
      if (t == open_kind) return 1'b1;
      case (open_kind)
         TK_TEXT:   return t == TK_NUMBER;
         TK_HEX:    return t == TK_NUMBER || (p == "0" && c == "x") ||
                           (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
         TK_NUMBER: return (c == dec_ch && digit(n)) || c == exp_ch ||
                           (p == exp_ch && (c == "+" || c == "-"));
         default:   return 1'b0;
      endcase
   endfunction

   function automatic bracket_type shape(input logic [7:0] c);
      if (c == "[" || c == "]") return BR_SQUARE;
      if (c == "{" || c == "}") return BR_CURLY;
      return BR_ROUND;
   endfunction

   // classify one byte given its lookahead and queue the result
   task automatic mark_byte(input logic [7:0] raw, input logic [7:0] nraw, input logic fin);
      logic [7:0] c, n;
      kind_type   k, t;
      logic       st;
      err_type    e;
      rsp_type    r;
      c = blank(raw);
      n = fin ? 8'h00 : blank(nraw);
      k = TK_SPACE;
      st = 1'b0;
      e = ERR_NONE;
      if (in_cmt) begin
         k = TK_COMMENT;
         if (c == 8'h0A) in_cmt = 1'b0;
      end else if (in_str && c == str_ch) begin
         k = TK_STRING;
         in_str = 1'b0;
      end else if (in_str && c != 8'h0A) begin
         k = TK_STRING;
      end else begin
         // newline inside a string closes it with an error
         if (in_str) begin
            e = ERR_UNTERM;
            in_str = 1'b0;
         end
         if (c == " ") begin
            open_kind = TK_SPACE;
         end else begin
            t = byte_kind(c, n);
            if (open_kind != TK_SPACE && t != TK_OPEN && t != TK_CLOSE &&
                continues(t, prev_byte, c, n)) begin
               k = open_kind;
            end else begin
               k = t;
               st = 1'b1;
               open_kind = TK_SPACE;
               case (t)
                  TK_TEXT, TK_NUMBER, TK_HEX, TK_OPER, TK_UNREC: open_kind = t;
                  TK_OPEN: begin
                     if (depth >= StackDepth) e = ERR_OVERFLOW;
                     else begin
                        brackets[depth] = shape(c);
                        depth++;
                     end
                  end
                  TK_CLOSE: begin
                     if (depth == 0) e = ERR_MISMATCH;
                     else begin
                        if (brackets[depth-1] != shape(c)) e = ERR_MISMATCH;
                        depth--;
                     end
                  end
                  TK_STRING:  in_str = 1'b1;
                  TK_COMMENT: in_cmt = 1'b1;
                  default: ;
               endcase
            end
         end
      end
      prev_byte = c;
      r.out_char = raw;
      r.token_kind = k;
      r.token_start = st;
      r.bracket_depth = depth[4:0];
      r.last = fin;
      // end of text: report what is left open, then clear for the next text
      if (fin) begin
         if (e == ERR_NONE && in_str) e = ERR_UNTERM;
         else if (e == ERR_NONE && depth != 0) e = ERR_UNCLOSED;
         open_kind = TK_SPACE;
         in_str = 1'b0;
         in_cmt = 1'b0;
         depth = 0;
         prev_byte = 8'h00;
      end
      r.error_code = e;
      awaited.insert(awaited.size(), r);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         cmt_ch = "#";
         str_ch = 8'd34;
         dec_ch = ".";
         exp_ch = "e";
         held_byte = 8'h00;
         prev_byte = 8'h00;
         held_ok = 1'b0;
         in_str = 1'b0;
         in_cmt = 1'b0;
         open_kind = TK_SPACE;
         depth = 0;
         awaited.delete();
         mismatch_count <= 0;
      end else begin
         if (csr_we) begin
            case (csr_idx_type'(csr_idx))
               CSR_COMMENT:  cmt_ch = csr_wdata;
               CSR_STRING:   str_ch = csr_wdata;
               CSR_DECIMAL:  dec_ch = csr_wdata;
               CSR_EXPONENT: exp_ch = csr_wdata;
               default: ;
            endcase
         end
         // one request releases the held byte, and itself when it ends the text
         if (req_valid && req_ready) begin
            if (held_ok) mark_byte(held_byte, req_payload[8:1], 1'b0);
            held_byte = req_payload[8:1];
            held_ok = 1'b1;
            if (req_payload[0]) begin
               mark_byte(held_byte, 8'h00, 1'b1);
               held_ok = 1'b0;
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited.size() == 0) begin
               if (mismatch_count < 10)
                  $display("unexpected result: %p", rsp_payload);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = awaited.pop_front();
               if (want.out_char !== rsp_payload.out_char ||
                   want.token_kind !== rsp_payload.token_kind ||
                   want.token_start !== rsp_payload.token_start ||
                   want.bracket_depth !== rsp_payload.bracket_depth ||
                   want.error_code !== rsp_payload.error_code ||
                   want.last !== rsp_payload.last) begin
                  if (mismatch_count < 10)
                     $display("mismatch: expected %p, got %p", want, rsp_payload);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
      end
      awaited_count <= awaited.size();
   end

endmodule

// ===== verif/tb_source_token_boundary_marker_unit.sv =====
// Testbench top for the source token boundary marker: clock, reset, request and csr stimulus,
// result back-pressure and the verdict. Depends on stbm_pkg, stbm_stream_if, stbm_checker.
module tb_source_token_boundary_marker_unit;
   import stbm_pkg::*;

   localparam int IdleLimit = 4000;
   localparam int RequestTarget = 1550;

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_we;
   logic [1:0] csr_idx;
   logic [7:0] csr_wdata;
   int         mismatches, outstanding, requests_sent, idle_cycles;
   logic       calm;
   logic [7:0] cur_cmt, cur_str, cur_dec, cur_exp;

   stbm_stream_if #(.PayloadType(logic [8:0])) req_if ();
   stbm_stream_if #(.PayloadType(rsp_type))    rsp_if ();

   source_token_boundary_marker_unit DUT (
      .clock(clock), .reset(reset), .req(req_if), .rsp(rsp_if),
      .csr_we(csr_we), .csr_idx(csr_idx), .csr_wdata(csr_wdata)
   );

   stbm_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_if.valid), .req_ready(req_if.ready), .req_payload(req_if.payload),
      .rsp_valid(rsp_if.valid), .rsp_ready(rsp_if.ready), .rsp_payload(rsp_if.payload),
      .csr_we(csr_we), .csr_idx(csr_idx), .csr_wdata(csr_wdata),
      .mismatch_count(mismatches), .awaited_count(outstanding)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // result side back-pressure in random bursts
   always @(posedge clock) begin
      int stall_left;
      if (reset || calm) begin
         stall_left = 0;
         rsp_if.ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_if.ready <= 1'b0;
      end else if ($urandom_range(0, 11) == 0) begin
         stall_left = $urandom_range(1, 12) - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic send_request(input logic [7:0] ch, input logic eot);
      if (!calm && $urandom_range(0, 9) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.payload <= {ch, eot};
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      requests_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_request(s[i], i == s.len() - 1);
   endtask

   // settings change only once every result is back and the pipe has drained
   task automatic write_setting(input csr_idx_type idx, input logic [7:0] val);
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      csr_we <= 1'b1;
      csr_idx <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_COMMENT:  cur_cmt = val;
         CSR_STRING:   cur_str = val;
         CSR_DECIMAL:  cur_dec = val;
         CSR_EXPONENT: cur_exp = val;
         default: ;
      endcase
   endtask

   task automatic write_all(input logic [7:0] c, input logic [7:0] s,
                            input logic [7:0] d, input logic [7:0] e);
      write_setting(CSR_COMMENT, c);
      write_setting(CSR_STRING, s);
      write_setting(CSR_DECIMAL, d);
      write_setting(CSR_EXPONENT, e);
   endtask

   // byte biased towards characters that shape tokens
   function automatic logic [7:0] pick_char();
      string alnum = "abcdefxyzABFQ_@";
      string punct = "+-*/=<>.,:;!?^|&%";
      string brk = "()[]{}";
      case ($urandom_range(0, 19))
         0, 1, 2:  return alnum[$urandom_range(0, alnum.len() - 1)];
         3, 4, 5:  return 8'("0") + 8'($urandom_range(0, 9));
         6:        return "x";
         7, 8:     return punct[$urandom_range(0, punct.len() - 1)];
         9, 10:    return brk[$urandom_range(0, 5)];
         11:       return cur_cmt;
         12:       return cur_str;
         13:       return cur_dec;
         14:       return cur_exp;
         15:       return 8'h0A;
         16: begin
            case ($urandom_range(0, 3))
               0: return 8'h09;
               1: return 8'h0D;
               2: return 8'hA4;
               default: return " ";
            endcase
         end
         17:       return " ";
         default:  return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic random_texts(input int count);
      int len;
      for (int i = 0; i < count; i++) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
         for (int j = 0; j < len; j++) send_request(pick_char(), j == len - 1);
      end
   endtask

   initial begin
      reset = 1'b1;
      calm = 1'b0;
      csr_we = 1'b0;
      csr_idx = CSR_COMMENT;
      csr_wdata = 8'h00;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      requests_sent = 0;
      cur_cmt = "#";
      cur_str = 8'd34;
      cur_dec = ".";
      cur_exp = "e";
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: numbers, hex, strings, comments, bracket errors, overflow
      send_text("ab1 12.5e+3 0x1F>=-");
      send_text({"\"s\t\n", "# c\r\n"});
      send_text("(]) }");
      send_text("((((((((((((((((((");
      send_text("[\"open");
      // high bytes and a zero byte
      send_request(8'hFF, 1'b0);
      send_request(8'hA4, 1'b0);
      send_request(8'h00, 1'b0);
      send_request(8'h80, 1'b1);

      random_texts(40);
      write_all("%", "'", ",", "E");
      random_texts(40);
      write_all(8'h00, 8'hFF, 8'h00, 8'hFF);
      random_texts(35);
      write_all(8'hFF, 8'h00, 8'hFF, 8'h00);
      random_texts(35);
      write_all("#", 8'd34, ".", "e");
      while (requests_sent < RequestTarget - 150) random_texts(1);
      calm = 1'b1;
      while (requests_sent < RequestTarget) random_texts(1);
      req_if.valid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
